>>> src/srec_lp_pkg.sv
// ---------------------------------------------------------------------------
// srec_lp_pkg
// shared types, codes and the hex nibble decode for the s-record line parser
// ---------------------------------------------------------------------------
`default_nettype none

package srec_lp_pkg;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

  localparam logic [7:0] CHR_S    = 8'h53;
  localparam logic [7:0] CHR_0    = 8'h30;
  localparam logic [7:0] CHR_1    = 8'h31;
  localparam logic [7:0] CHR_5    = 8'h35;
  localparam logic [7:0] CHR_9    = 8'h39;
  localparam logic [7:0] CHR_LA   = 8'h61;
  localparam logic [7:0] CHR_LF   = 8'h66;
  localparam logic [7:0] CHR_UA   = 8'h41;
  localparam logic [7:0] CHR_UF   = 8'h46;
  localparam logic [7:0] LA_BIAS  = 8'h57;
  localparam logic [7:0] UA_BIAS  = 8'h37;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_S      = 3'd1;
  localparam logic [2:0] ST_BAD_CKSUM = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       type_digit;
    logic [7:0]       byte_total;
    logic [7:0]       bytes_left;
    logic [7:0]       running_sum;
    logic [3:0]       high_nibble;
    logic [15:0]      rec_addr;
    logic [7:0]       payload_offset;
    logic [2:0]       err;
    logic             cksum_seen;
  } line_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] byte_address;
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic [3:0]  record_type;
  } result_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] diff;
    begin
      if (c >= CHR_0 && c <= CHR_9) begin
        diff = c - CHR_0;
      end else if (c >= CHR_LA && c <= CHR_LF) begin
        diff = c - LA_BIAS;
      end else if (c >= CHR_UA && c <= CHR_UF) begin
        diff = c - UA_BIAS;
      end else begin
        diff = c;
      end
      nibble_of = diff[3:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/srec_lp_step.sv
// ---------------------------------------------------------------------------
// srec_lp_step
// one character of line decode: next line state and optional result
// ---------------------------------------------------------------------------
`default_nettype none

module srec_lp_step
  import srec_lp_pkg::*;
(
  input  wire line_state_t state_i,
  input  wire logic [7:0]  char_code,
  input  wire logic        line_end,
  output line_state_t      state_nxt,
  output logic             emit,
  output result_t          res
);

  logic [3:0] nib;
  logic [7:0] b;
  logic [7:0] idx;
  logic       type_ok;

  assign nib     = nibble_of(char_code);
  assign b       = {state_i.high_nibble, nib};
  assign idx     = state_i.byte_total - state_i.bytes_left;
  assign type_ok = (char_code == CHR_0) || (char_code == CHR_1) ||
                   (char_code == CHR_5) || (char_code == CHR_9);

  always_comb begin
    state_nxt = state_i;
    emit      = 1'b0;
    res       = '0;
    if (line_end) begin
      emit            = 1'b1;
      res.kind        = KIND_STATUS;
      res.record_type = state_i.type_digit;
      if (state_i.pos == '0 || state_i.err == ST_NO_S) begin
        res.status = ST_NO_S;
      end else if (!state_i.cksum_seen || state_i.byte_total < 8'd3) begin
        res.status = ST_BAD_LEN;
      end else begin
        res.status = state_i.err;
      end
      state_nxt = '0;
    end else begin
      if (state_i.pos == '0) begin
        if (char_code != CHR_S) begin
          state_nxt.err = ST_NO_S;
        end
      end else if (state_i.pos == POS_W'(1)) begin
        state_nxt.type_digit = nib;
        if (!type_ok && state_i.err == ST_OK) begin
          state_nxt.err = ST_BAD_TYPE;
        end
      end else if (state_i.pos < POS_W'(4) || state_i.bytes_left != 8'd0) begin
        if (!state_i.pos[0]) begin
          state_nxt.high_nibble = nib;
        end else if (state_i.pos == POS_W'(3)) begin
          state_nxt.byte_total     = b;
          state_nxt.bytes_left     = b;
          state_nxt.running_sum    = b;
          state_nxt.payload_offset = 8'd0;
        end else if (state_i.bytes_left == 8'd1) begin
          state_nxt.cksum_seen = 1'b1;
          state_nxt.bytes_left = 8'd0;
          if (b != ~state_i.running_sum &&
              (state_i.err == ST_OK || state_i.err == ST_BAD_TYPE)) begin
            state_nxt.err = ST_BAD_CKSUM;
          end
        end else begin
          state_nxt.running_sum = state_i.running_sum + b;
          state_nxt.bytes_left  = state_i.bytes_left - 8'd1;
          if (idx == 8'd0) begin
            state_nxt.rec_addr = {b, 8'h00};
          end else if (idx == 8'd1) begin
            state_nxt.rec_addr = state_i.rec_addr | {8'h00, b};
          end else if (state_i.type_digit <= 4'd1 && state_i.err != ST_BAD_TYPE) begin
            emit             = 1'b1;
            res.kind         = (state_i.type_digit == 4'd0) ? KIND_HEADER : KIND_DATA;
            res.byte_address = state_i.rec_addr + {8'h00, state_i.payload_offset};
            res.byte_value   = b;
            res.status       = ST_OK;
            res.record_type  = state_i.type_digit;
            state_nxt.payload_offset = state_i.payload_offset + 8'd1;
          end
        end
      end
      if (state_i.pos != POS_MAX) begin
        state_nxt.pos = state_i.pos + POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/srec_line_parser_unit.sv
// ---------------------------------------------------------------------------
// srec_line_parser_unit
// streaming motorola s-record line parser, one character per transaction
// ---------------------------------------------------------------------------
// The in_ channel carries one ASCII character per transaction in in_tdata;
// in_tlast marks end of line (the character is then ignored) and asks for
// the line status. The out_ channel gives S0/S1 payload bytes with their
// address as each hex pair completes, and one status transaction per line
// end; out_tuser holds the kind (data, header, status).
// A transaction is registered on entry, decoded combinationally against the
// line state and registered again on exit. One character is taken every
// cycle while the receiver does not stall; the decode and the state update
// form a combinational loop through the line state register.
// When the receiver stalls, the result register holds and the input
// register fills; in_tready then drops until out_tready returns.
// Synchronous reset (rst_n low) empties both registers and clears the
// line state, as does every end of line.
// ---------------------------------------------------------------------------
`default_nettype none

module srec_line_parser_unit
  import srec_lp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] byte_address, [23:16] byte_value,
                                       // [26:24] status, [30:27] record_type
  output logic [1:0]       out_tuser   // [1:0] kind
);

  logic        in_valid_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;
  line_state_t state_r;
  line_state_t state_nxt;
  logic        out_valid_r;
  result_t     out_res_r;
  logic        step_emit;
  result_t     step_res;
  logic        advance;
  logic        in_take;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  srec_lp_step u_step (
    .state_i   (state_r),
    .char_code (in_char_r),
    .line_end  (in_last_r),
    .state_nxt (state_nxt),
    .emit      (step_emit),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= step_emit;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {1'b0, out_res_r.record_type, out_res_r.status,
                       out_res_r.byte_value, out_res_r.byte_address};

`ifndef SYNTHESIS
  a_status_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == KIND_STATUS |->
      out_res_r.byte_address == 16'd0 && out_res_r.byte_value == 8'd0)
    else $error("status transaction carries payload");

  a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind != KIND_STATUS |-> out_res_r.status == ST_OK)
    else $error("byte transaction carries a status");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> state_r == '0 && out_valid_r)
    else $error("line end did not clear state or give a status");
`endif

endmodule

`default_nettype wire
